FILE: rtl/core/drm_pkg.sv
`default_nettype none
package drm_pkg;

	// Command codes carried on the input channel.
	localparam logic CMD_MARK  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Sequencer states of the tracker.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BOX,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_PASS_RD,
		ST_PASS_CMP,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_WRITE_BACK,
		ST_APPEND,
		ST_FL_RD,
		ST_FL_OUT,
		ST_FL_ONE
	} drm_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/drm_in_if.sv
`default_nettype none
interface drm_in_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [COORD_BITS-1:0] rect_left;
	logic [COORD_BITS-1:0] rect_top;
	logic [COORD_BITS-1:0] rect_width;
	logic [COORD_BITS-1:0] rect_height;

	modport source (
		output valid, cmd, rect_left, rect_top, rect_width, rect_height,
		input  ready
	);
	modport sink (
		input  valid, cmd, rect_left, rect_top, rect_width, rect_height,
		output ready
	);
endinterface
`default_nettype wire

FILE: rtl/core/drm_out_if.sv
`default_nettype none
interface drm_out_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] out_x;
	logic [COORD_BITS-1:0] out_y;
	logic [COORD_BITS:0]   out_w;
	logic [COORD_BITS:0]   out_h;
	logic                  is_empty;
	logic                  is_last;

	modport source (
		output valid, out_x, out_y, out_w, out_h, is_empty, is_last,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_w, out_h, is_empty, is_last,
		output ready
	);
endinterface
`default_nettype wire

FILE: rtl/core/drm_ram.sv
`default_nettype none
module drm_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 48,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/drm_rect_unit.sv
`default_nettype none
module drm_rect_unit #(
	parameter int CB = 13
) (
	input  wire logic [4*CB-1:0] rect_a,
	input  wire logic [4*CB-1:0] rect_b,
	output logic                 touch,
	output logic [4*CB-1:0]      grown
);
	logic [CB-1:0] al, at, ar, ab, bl, bt, br, bb;

	assign {al, at, ar, ab} = rect_a;
	assign {bl, bt, br, bb} = rect_b;

	// Shared edges count as touching.
	assign touch = !((al > br) || (ar < bl) || (at > bb) || (ab < bt));

	assign grown = {(bl < al) ? bl : al,
	                (bt < at) ? bt : at,
	                (br > ar) ? br : ar,
	                (bb > ab) ? bb : ab};
endmodule
`default_nettype wire

FILE: rtl/core/dirty_rect_merge_tracker.sv
`default_nettype none
// Dirty rectangle tracker with list merging.
// Items arrive on in_ch (valid/ready). A mark (cmd = 0) records a damaged
// rectangle and produces nothing; a flush (cmd = 1) sends the tracked
// regions on out_ch, one transfer per region, the final one flagged
// is_last, and then clears the tracking state. force_bbox is written
// through cfg_wr_en/cfg_wr_data; the user must do so only while the block
// is idle, as the block itself does not enforce this. A zero-sized mark
// is dropped and a bounding-box-only mark just grows the box; otherwise a
// mark grows the box, scans the stored entries for one that it touches,
// checks each later entry in an absorb pass, absorbing those that touch,
// and then writes back the grown entry or appends the mark. Marks are
// handled one at a time, serialised by the single read port of the
// rectangle store and the one shared touch/grow unit. A flush reads and
// sends each stored rectangle in turn, or one bounding-box or empty result.
// Results sit in an output register; a stall on out_ch simply holds the
// sequencer in its emit state, and the next input is taken as soon as the
// last result has been loaded, even while it still waits to be taken.
// Reset clears the count, overflow flag, bounding box and force_bbox at
// once; the store itself needs no clearing as only entries below the
// count are ever read.
module dirty_rect_merge_tracker #(
	parameter int MAX_RECTS  = 48,
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	drm_in_if.sink    in_ch,
	drm_out_if.source out_ch,
	input  wire logic cfg_wr_en,
	input  wire logic cfg_wr_data
);
	import drm_pkg::*;

	localparam int CB = COORD_BITS + 1;
	localparam int RW = 4 * CB;
	localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam logic [RW-1:0] BOX_RESET = {{CB{1'b1}}, {CB{1'b1}}, {CB{1'b0}}, {CB{1'b0}}};

	drm_state_t state_q, state_d;

	logic          force_bbox_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [RW-1:0] box_q;
	logic [RW-1:0] new_q;
	logic [RW-1:0] work_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [CB-1:0]         out_w_q, out_h_q;
	logic                  out_empty_q, out_last_q;

	logic          in_xfer;
	logic          out_free;
	logic          out_load;
	logic          bbox_mode;
	logic [CW-1:0] i_inc, j_dec, cnt_dec;
	logic          is_last_entry;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;

	logic [RW-1:0] unit_a, unit_b, unit_grown;
	logic          unit_touch;

	logic [CB-1:0] rd_l, rd_t, rd_r, rd_b;
	logic [CB-1:0] bx_l, bx_t, bx_r, bx_b;
	logic          box_ok;

	assign in_xfer   = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign out_load  = ((state_q == ST_FL_OUT) || (state_q == ST_FL_ONE)) && out_free;
	assign bbox_mode = ovf_q || force_bbox_q;
	assign i_inc     = i_q + CW'(1);
	assign j_dec     = j_q - CW'(1);
	assign cnt_dec   = cnt_q - CW'(1);
	assign is_last_entry = (i_inc == cnt_q);

	assign {rd_l, rd_t, rd_r, rd_b} = ram_rdata;
	assign {bx_l, bx_t, bx_r, bx_b} = box_q;
	assign box_ok = (bx_r > bx_l) && (bx_b > bx_t);

	// The shared compare unit sees the bounding box while it grows, the
	// stored entry against the new mark during the scan, and the stored
	// entry against the grown rectangle during the absorb pass.
	assign unit_a = (state_q == ST_BOX) ? box_q : ram_rdata;
	assign unit_b = (state_q == ST_PASS_CMP) ? work_q : new_q;

	drm_rect_unit #(.CB(CB)) u_unit (
		.rect_a (unit_a),
		.rect_b (unit_b),
		.touch  (unit_touch),
		.grown  (unit_grown)
	);

	drm_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS), .AW(AW)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ch.ready     = (state_q == ST_IDLE);
	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_x    = out_x_q;
	assign out_ch.out_y    = out_y_q;
	assign out_ch.out_w    = out_w_q;
	assign out_ch.out_h    = out_h_q;
	assign out_ch.is_empty = out_empty_q;
	assign out_ch.is_last  = out_last_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_ch.cmd == CMD_FLUSH) begin
						state_d = (bbox_mode || cnt_q == '0) ? ST_FL_ONE : ST_FL_RD;
					end else if (in_ch.rect_width != '0 && in_ch.rect_height != '0) begin
						state_d = ST_BOX;
					end
				end
			end
			ST_BOX: begin
				if (bbox_mode) begin
					state_d = ST_IDLE;
				end else if (cnt_q == '0) begin
					state_d = ST_APPEND;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (unit_touch) begin
					state_d = (cnt_dec > i_q) ? ST_PASS_RD : ST_WRITE_BACK;
				end else begin
					state_d = is_last_entry ? ST_APPEND : ST_SCAN_RD;
				end
			end
			ST_PASS_RD: state_d = ST_PASS_CMP;
			ST_PASS_CMP: begin
				if (unit_touch) begin
					state_d = ST_MOVE_RD;
				end else begin
					state_d = (j_dec == i_q) ? ST_WRITE_BACK : ST_PASS_RD;
				end
			end
			ST_MOVE_RD: state_d = ST_MOVE_WR;
			ST_MOVE_WR: state_d = (j_dec == i_q) ? ST_WRITE_BACK : ST_PASS_RD;
			ST_WRITE_BACK: state_d = ST_IDLE;
			ST_APPEND: state_d = ST_IDLE;
			ST_FL_RD: state_d = ST_FL_OUT;
			ST_FL_OUT: begin
				if (out_free) begin
					state_d = is_last_entry ? ST_IDLE : ST_FL_RD;
				end
			end
			ST_FL_ONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Store port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q[AW-1:0];
		ram_wdata = work_q;
		ram_raddr = i_q[AW-1:0];
		case (state_q)
			ST_PASS_RD: ram_raddr = j_q[AW-1:0];
			ST_MOVE_RD: ram_raddr = cnt_q[AW-1:0];
			ST_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			ST_WRITE_BACK: ram_we = 1'b1;
			ST_APPEND: begin
				ram_we    = (cnt_q != CW'(MAX_RECTS));
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = new_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			force_bbox_q <= 1'b0;
			ovf_q        <= 1'b0;
			cnt_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			box_q        <= BOX_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				force_bbox_q <= cfg_wr_data;
			end
			// A new result replaces the one taken in the same cycle.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: i_q <= '0;
				ST_BOX: box_q <= unit_grown;
				ST_SCAN_CMP: begin
					j_q <= cnt_dec;
					if (!unit_touch) begin
						i_q <= i_inc;
					end
				end
				ST_PASS_CMP: begin
					if (unit_touch) begin
						cnt_q <= cnt_dec;
					end else begin
						j_q <= j_dec;
					end
				end
				ST_MOVE_WR: j_q <= j_dec;
				ST_APPEND: begin
					if (cnt_q == CW'(MAX_RECTS)) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_FL_OUT: begin
					if (out_free) begin
						i_q <= i_inc;
						if (is_last_entry) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							box_q <= BOX_RESET;
						end
					end
				end
				ST_FL_ONE: begin
					if (out_free) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						box_q <= BOX_RESET;
					end
				end
				default: i_q <= i_q;
			endcase
		end
	end

	// Working rectangles and the output register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			new_q <= {1'b0, in_ch.rect_left,
			          1'b0, in_ch.rect_top,
			          CB'({1'b0, in_ch.rect_left}) + CB'({1'b0, in_ch.rect_width}),
			          CB'({1'b0, in_ch.rect_top}) + CB'({1'b0, in_ch.rect_height})};
		end
		if (state_q == ST_SCAN_CMP || state_q == ST_PASS_CMP) begin
			if (unit_touch) begin
				work_q <= unit_grown;
			end
		end
		if (state_q == ST_FL_OUT && out_free) begin
			out_x_q     <= rd_l[COORD_BITS-1:0];
			out_y_q     <= rd_t[COORD_BITS-1:0];
			out_w_q     <= rd_r - rd_l;
			out_h_q     <= rd_b - rd_t;
			out_empty_q <= 1'b0;
			out_last_q  <= is_last_entry;
		end
		if (state_q == ST_FL_ONE && out_free) begin
			out_last_q <= 1'b1;
			if (bbox_mode && box_ok) begin
				out_x_q     <= bx_l[COORD_BITS-1:0];
				out_y_q     <= bx_t[COORD_BITS-1:0];
				out_w_q     <= bx_r - bx_l;
				out_h_q     <= bx_b - bx_t;
				out_empty_q <= 1'b0;
			end else begin
				out_x_q     <= '0;
				out_y_q     <= '0;
				out_w_q     <= '0;
				out_h_q     <= '0;
				out_empty_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire
